// ===== rtl/mpc_pkg.sv =====
// Package for the masked popcount correlation core: field widths, register
// indexes, sequencer states and divider request/response types.
// No dependencies.
package mpc_pkg;

    localparam int COORD_W     = 14;
    localparam int WORD_W      = 64;
    localparam int SUM_W       = 13;
    localparam int POP_W       = 7;
    localparam int SCORE_W     = 8;
    localparam int CFG_W       = 15;
    localparam int CFG_ADDR_W  = 3;
    localparam int S_TDATA_W   = 224;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;
    localparam int MUL_W       = 16;
    localparam int PROD_W      = 32;
    localparam int DIVIDEND_W  = 20;
    localparam int DIVISOR_W   = 13;
    localparam int DIV_STEPS   = DIVIDEND_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [SUM_W-1:0]   SUM_MAX      = 13'h1FFF;
    localparam logic [SCORE_W-1:0] EMPTY_ENTRY  = 8'd255;
    localparam logic [SCORE_W-1:0] SCORE_MAX    = 8'd254;
    localparam logic [MUL_W-1:0]   SCORE_SCALE  = 16'd100;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMAGE_ROWS    = 3'd0,
        CFG_IMAGE_COLUMNS = 3'd1,
        CFG_MASK_HEIGHT   = 3'd2,
        CFG_ON_COUNT      = 3'd3,
        CFG_WINDOW_X0     = 3'd4,
        CFG_WINDOW_Y0     = 3'd5,
        CFG_WINDOW_WIDTH  = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP_OFF,
        ST_MUL_IDX,
        ST_MUL_POS,
        ST_MUL_AREA,
        ST_MUL_DIFF,
        ST_DIV,
        ST_EMIT
    } mpc_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/masked_popcount_correlation_core.sv =====
// Top level of the masked popcount correlation core: stream ports, sequencer,
// shared multiplier, score cache. Depends on mpc_pkg, mpc_popcount, mpc_divider.
//
// Usage
//   Input stream (s_*): one word per 64-bit image slice with its on-mask and
//   off-mask words and the point's coordinates; s_tlast marks the final slice
//   of a run. Output stream (m_*): one word per run, carrying the 8-bit score
//   and the cache-hit / index-error flags. Configuration is a plain write port
//   (cfg_wr_en, cfg_addr, cfg_wdata); write it only while the core is idle.
// Sequence
//   Each input word goes through one shared popcount tree: the on-mask popcount
//   in the accept cycle, the off-mask popcount in the next.
//   After the last word of a run: the index, position, area and diff*100
//   products on one shared 16x16 multiplier, then the bit-serial divider when
//   a fresh score is computed, then the load of the output register. A cache hit,
//   out-of-range point or bad index skips the divider.
// Reset
//   Clears the sums and the registers to their defaults, then sweeps the score
//   cache to empty, one entry a cycle, with s_tready low.
// Back-pressure
//   The result holds in the output register until m_tready; the core keeps
//   taking input words meanwhile and only waits at the end of the next run.
module masked_popcount_correlation_core
    import mpc_pkg::*;
#(
    parameter int CACHE_DEPTH = 16384
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // from bit 0: x_pos[13:0], y_pos[13:0], image_word[63:0], on_mask_word[63:0],
    // off_mask_word[63:0], zero fill[3:0]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,      // last_word
    // master side
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,      // from bit 0: score[7:0]
    output logic [M_TUSER_W-1:0]  m_tuser,      // from bit 0: cache_hit, index_error
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int AW = $clog2(CACHE_DEPTH);
    localparam logic signed [PROD_W-1:0] IdxLimit = PROD_W'(CACHE_DEPTH);

    // input fields
    logic [COORD_W-1:0] in_x, in_y;
    logic [WORD_W-1:0]  in_image, in_on, in_off;

    assign in_x     = s_tdata[13:0];
    assign in_y     = s_tdata[27:14];
    assign in_image = s_tdata[91:28];
    assign in_on    = s_tdata[155:92];
    assign in_off   = s_tdata[219:156];

    // configuration registers
    logic [14:0] rows_reg, cols_reg, win_width_reg;
    logic [7:0]  mheight_reg;
    logic [12:0] on_count_reg;
    logic [13:0] win_x0_reg, win_y0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= 15'd1;
            cols_reg      <= 15'd1;
            mheight_reg   <= 8'd2;
            on_count_reg  <= 13'd1;
            win_x0_reg    <= '0;
            win_y0_reg    <= '0;
            win_width_reg <= 15'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_IMAGE_ROWS:    rows_reg      <= cfg_wdata;
                CFG_IMAGE_COLUMNS: cols_reg      <= cfg_wdata;
                CFG_MASK_HEIGHT:   mheight_reg   <= cfg_wdata[7:0];
                CFG_ON_COUNT:      on_count_reg  <= cfg_wdata[12:0];
                CFG_WINDOW_X0:     win_x0_reg    <= cfg_wdata[13:0];
                CFG_WINDOW_Y0:     win_y0_reg    <= cfg_wdata[13:0];
                CFG_WINDOW_WIDTH:  win_width_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // sequencer and datapath registers
    mpc_state_t state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [SUM_W-1:0]   on_sum_reg, on_sum_next;
    logic [SUM_W-1:0]   off_sum_reg, off_sum_next;
    logic               out_valid_reg, out_valid_next;

    logic [COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic               last_reg, last_next;
    logic [WORD_W-1:0]  off_and_reg, off_and_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] idx_reg, idx_next;
    logic signed [PROD_W-1:0] pos_reg, pos_next;
    logic [SCORE_W-1:0] res_score_reg, res_score_next;
    logic               res_hit_reg, res_hit_next;
    logic               res_err_reg, res_err_next;
    logic               res_store_reg, res_store_next;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;
    logic               out_hit_reg, out_hit_next;
    logic               out_err_reg, out_err_next;

    // shared popcount: on-mask straight from the port, off-mask from the register
    logic [WORD_W-1:0] pop_bits;
    logic [POP_W-1:0]  pop_count;
    logic [SUM_W:0]    on_acc, off_acc;

    assign pop_bits = (state_reg == ST_IDLE) ? (in_image & in_on) : off_and_reg;

    mpc_popcount u_popcount
    (
        .bits  (pop_bits),
        .count (pop_count)
    );

    assign on_acc  = {1'b0, on_sum_reg}  + {{(SUM_W-POP_W+1){1'b0}}, pop_count};
    assign off_acc = {1'b0, off_sum_reg} + {{(SUM_W-POP_W+1){1'b0}}, pop_count};

    // shared signed multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [MUL_W-1:0]  dx, dy;
    logic [SUM_W-1:0]         diff;

    assign dx    = $signed({2'b00, x_reg}) - $signed({2'b00, win_x0_reg});
    assign dy    = $signed({2'b00, y_reg}) - $signed({2'b00, win_y0_reg});
    assign diff  = (on_sum_reg > off_sum_reg) ? (on_sum_reg - off_sum_reg) : '0;
    assign mul_p = mul_a * mul_b;

    // range tests
    logic signed [PROD_W-1:0] limit;
    logic                     in_range;
    logic                     idx_err;

    assign limit    = prod_reg - $signed({25'b0, mheight_reg[7:1]});
    assign in_range = pos_reg <= limit;
    assign idx_err  = idx_reg[PROD_W-1] || (idx_reg >= IdxLimit);

    // divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    mpc_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // score cache
    logic [SCORE_W-1:0] cache_mem [CACHE_DEPTH];
    logic [SCORE_W-1:0] cache_rdata_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [SCORE_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cache_mem[mem_waddr] <= mem_wdata;
        end
        cache_rdata_reg <= cache_mem[idx_reg[AW-1:0]];
    end

    logic emit_go;

    assign emit_go = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        on_sum_next    = on_sum_reg;
        off_sum_next   = off_sum_reg;
        out_valid_next = out_valid_reg && !m_tready;
        x_next         = x_reg;
        y_next         = y_reg;
        last_next      = last_reg;
        off_and_next   = off_and_reg;
        prod_next      = prod_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        res_score_next = res_score_reg;
        res_hit_next   = res_hit_reg;
        res_err_next   = res_err_reg;
        res_store_next = res_store_reg;
        out_score_next = out_score_reg;
        out_hit_next   = out_hit_reg;
        out_err_next   = out_err_reg;
        mul_a          = '0;
        mul_b          = '0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[AW-1:0];
        mem_wdata      = res_score_reg;
        div_req.start    = 1'b0;
        div_req.dividend = mul_p[DIVIDEND_W-1:0];
        div_req.divisor  = (on_count_reg == '0) ? DIVISOR_W'(1) : on_count_reg;
        s_tready       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep the cache to empty after reset
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = EMPTY_ENTRY;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(CACHE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    on_sum_next  = on_acc[SUM_W] ? SUM_MAX : on_acc[SUM_W-1:0];
                    off_and_next = in_image & in_off;
                    x_next       = in_x;
                    y_next       = in_y;
                    last_next    = s_tlast;
                    state_next   = ST_POP_OFF;
                end
            end
            ST_POP_OFF:
            begin
                off_sum_next = off_acc[SUM_W] ? SUM_MAX : off_acc[SUM_W-1:0];
                state_next   = last_reg ? ST_MUL_IDX : ST_IDLE;
            end
            ST_MUL_IDX:
            begin
                mul_a      = dy;
                mul_b      = $signed({1'b0, win_width_reg});
                prod_next  = mul_p;
                state_next = ST_MUL_POS;
            end
            ST_MUL_POS:
            begin
                idx_next   = {{(PROD_W-MUL_W){dx[MUL_W-1]}}, dx} + prod_reg;
                mul_a      = $signed({2'b00, x_reg});
                mul_b      = $signed({1'b0, rows_reg});
                prod_next  = mul_p;
                state_next = ST_MUL_AREA;
            end
            ST_MUL_AREA:
            begin
                // cache read of idx_reg is under way this cycle
                pos_next   = $signed({18'b0, y_reg}) + prod_reg;
                mul_a      = $signed({1'b0, cols_reg});
                mul_b      = $signed({1'b0, rows_reg});
                prod_next  = mul_p;
                state_next = ST_MUL_DIFF;
            end
            ST_MUL_DIFF:
            begin
                mul_a          = $signed({3'b000, diff});
                mul_b          = $signed(SCORE_SCALE);
                res_score_next = '0;
                res_hit_next   = 1'b0;
                res_err_next   = 1'b0;
                res_store_next = 1'b0;
                state_next     = ST_EMIT;
                if (idx_err)
                begin
                    res_err_next = 1'b1;
                end
                else if (cache_rdata_reg != EMPTY_ENTRY)
                begin
                    res_score_next = cache_rdata_reg;
                    res_hit_next   = 1'b1;
                end
                else if (in_range)
                begin
                    // fresh score: hand diff*100 to the divider
                    div_req.start  = 1'b1;
                    res_store_next = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_score_next = (div_rsp.quotient > {12'b0, SCORE_MAX})
                                   ? SCORE_MAX : div_rsp.quotient[SCORE_W-1:0];
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    mem_we         = res_store_reg;
                    out_valid_next = 1'b1;
                    out_score_next = res_score_reg;
                    out_hit_next   = res_hit_reg;
                    out_err_next   = res_err_reg;
                    on_sum_next    = '0;
                    off_sum_next   = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            on_sum_reg    <= '0;
            off_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            on_sum_reg    <= on_sum_next;
            off_sum_reg   <= off_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        last_reg      <= last_next;
        off_and_reg   <= off_and_next;
        prod_reg      <= prod_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        res_score_reg <= res_score_next;
        res_hit_reg   <= res_hit_next;
        res_err_reg   <= res_err_next;
        res_store_reg <= res_store_next;
        out_score_reg <= out_score_next;
        out_hit_reg   <= out_hit_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_score_reg;
    assign m_tuser  = {out_err_reg, out_hit_reg};

endmodule

// ===== rtl/mpc_popcount.sv =====
// 64-bit population count as a balanced adder tree.
// Depends on mpc_pkg.
module mpc_popcount
    import mpc_pkg::*;
(
    input  logic [WORD_W-1:0] bits,
    output logic [POP_W-1:0]  count
);

    logic [1:0] lvl1 [32];
    logic [2:0] lvl2 [16];
    logic [3:0] lvl3 [8];
    logic [4:0] lvl4 [4];
    logic [5:0] lvl5 [2];

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            lvl1[i] = {1'b0, bits[2*i]} + {1'b0, bits[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            lvl5[i] = {1'b0, lvl4[2*i]} + {1'b0, lvl4[2*i+1]};
        end
        count = {1'b0, lvl5[0]} + {1'b0, lvl5[1]};
    end

endmodule

// ===== rtl/mpc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on mpc_pkg.
module mpc_divider
    import mpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when the divisor fits
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/mpc_checker.sv =====
// Port-level assertions for the masked popcount correlation core, bound to
// the top level. Depends on masked_popcount_correlation_core.
module mpc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // drop ready for the off-mask cycle after every accepted word
    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("cache hit and index error together");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == 8'd0)
        else $error("index error with non-zero score");

    // the empty marker never leaves the core
    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata != 8'd255)
        else $error("empty cache marker given as a score");

endmodule

bind masked_popcount_correlation_core mpc_checker u_mpc_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for masked_popcount_correlation_core: stream words in,
// scores out, each score checked against a score predictor held in this file.
// Depends on mpc_pkg and the core itself; nothing else.
`timescale 1ns / 100ps

module tb;

    import mpc_pkg::*;

    localparam int CACHE_DEPTH     = 16384;
    localparam int SETTLE_CYCLES   = 40;     // index/position products, divider, output load
    localparam int HOLD_OFF_CYCLES = 300;    // long enough to fill the core and stall its input
    localparam int WATCHDOG_LIMIT  = 4 * CACHE_DEPTH + 2000;  // covers the cache sweep
    localparam int MAX_REPORTS     = 100;

    typedef struct {
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [WORD_W-1:0]  image_word;
        logic [WORD_W-1:0]  on_mask_word;
        logic [WORD_W-1:0]  off_mask_word;
        logic               last_word;
    } slice_t;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic               cache_hit;
        logic               index_error;
    } score_result_t;

    typedef struct {
        logic [14:0] image_rows;
        logic [14:0] image_columns;
        logic [7:0]  mask_height;
        logic [12:0] on_count;
        logic [13:0] window_x0;
        logic [13:0] window_y0;
        logic [14:0] window_width;
    } core_regs_t;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the core
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_IMAGE_ROWS;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    masked_popcount_correlation_core #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // from bit 0: x_pos, y_pos, image, on mask, off mask, fill
        .s_tlast   (s_tlast),     // last_word
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // from bit 0: score
        .m_tuser   (m_tuser),     // from bit 0: cache_hit, index_error
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Score predictor state: its own register copy, running sums and a
    // mirror of the score cache (255 means the slot is empty).
    // ------------------------------------------------------------------
    core_regs_t          live_regs;
    int unsigned         on_total;
    int unsigned         off_total;
    logic [SCORE_W-1:0]  score_memo [CACHE_DEPTH];
    score_result_t       pending_scores [$];

    logic [2*COORD_W-1:0] recent_points [$];   // {y, x} of recent fresh points, for cache hits

    int  mismatch_count   = 0;
    int  slices_sent      = 0;
    int  quiet_cycles     = 0;
    bit  sender_idles     = 1'b1;
    bit  sink_idles       = 1'b1;
    bit  hold_off_request = 1'b0;
    bit  pad_junk         = 1'b0;

    initial
    begin
        foreach (score_memo[i])
            score_memo[i] = EMPTY_ENTRY;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int unsigned clamp_sum(input int unsigned v);
        return (v > SUM_MAX) ? int'(SUM_MAX) : v;
    endfunction

    // Fold one accepted word into the sums; on the last word of a run work
    // out the score exactly as the core should and queue it.
    function automatic void accumulate_and_score(input slice_t w);
        longint        slot_index;
        longint        point_pos;
        longint        pos_limit;
        int unsigned   diff;
        int unsigned   divisor;
        int unsigned   quotient;
        score_result_t r;

        on_total  = clamp_sum(on_total + $countones(w.image_word & w.on_mask_word));
        off_total = clamp_sum(off_total + $countones(w.image_word & w.off_mask_word));
        if (!w.last_word)
            return;

        r.score       = '0;
        r.cache_hit   = 1'b0;
        r.index_error = 1'b0;

        // Only the last word's coordinates count.
        slot_index = (longint'(w.x_pos) - longint'(live_regs.window_x0))
                   + (longint'(w.y_pos) - longint'(live_regs.window_y0))
                   * longint'(live_regs.window_width);

        if (slot_index < 0 || slot_index >= CACHE_DEPTH) begin
            r.index_error = 1'b1;
        end else if (score_memo[slot_index] != EMPTY_ENTRY) begin
            r.score     = score_memo[slot_index];
            r.cache_hit = 1'b1;
        end else begin
            point_pos = longint'(w.y_pos) + longint'(w.x_pos) * longint'(live_regs.image_rows);
            pos_limit = longint'(live_regs.image_columns) * longint'(live_regs.image_rows)
                      - longint'(live_regs.mask_height >> 1);
            // Out-of-range points score zero and leave the cache alone.
            if (point_pos <= pos_limit) begin
                diff     = (on_total > off_total) ? on_total - off_total : 0;
                divisor  = (live_regs.on_count == 0) ? 1 : live_regs.on_count;
                quotient = diff * 100 / divisor;
                r.score  = (quotient > SCORE_MAX) ? SCORE_MAX : 8'(quotient);
                score_memo[slot_index] = r.score;
            end
        end

        on_total  = 0;
        off_total = 0;
        pending_scores.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Result side: check every accepted score word against the oldest
    // expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : score_check
        score_result_t want;
        if (m_tvalid === 1'b1 && m_tready) begin
            if (pending_scores.size() == 0) begin
                report_mismatch($sformatf("score word %0d with no score pending", m_tdata));
            end else begin
                want = pending_scores.pop_front();
                if (m_tdata !== want.score)
                    report_mismatch($sformatf("score %0d, predicted %0d", m_tdata, want.score));
                if (m_tuser[0] !== want.cache_hit)
                    report_mismatch($sformatf("cache_hit %b, predicted %b",
                                              m_tuser[0], want.cache_hit));
                if (m_tuser[1] !== want.index_error)
                    report_mismatch($sformatf("index_error %b, predicted %b",
                                              m_tuser[1], want.index_error));
            end
        end
    end

    // Drop m_tready in random bursts, or for one long hold-off on request.
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end else if (sink_idles && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("masked_popcount_correlation_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one word, hold it until taken, then predict and maybe idle.
    task automatic send_slice(input slice_t w);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, w.off_mask_word, w.on_mask_word, w.image_word, w.y_pos, w.x_pos};
        s_tlast  <= w.last_word;
        do
            @(posedge clk);
        while (!s_tready);
        slices_sent++;
        accumulate_and_score(w);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    function automatic slice_t make_slice(input int unsigned x, input int unsigned y,
                                          input logic [WORD_W-1:0] img,
                                          input logic [WORD_W-1:0] on_mask,
                                          input logic [WORD_W-1:0] off_mask,
                                          input logic last);
        slice_t w;
        w.x_pos         = x[COORD_W-1:0];
        w.y_pos         = y[COORD_W-1:0];
        w.image_word    = img;
        w.on_mask_word  = on_mask;
        w.off_mask_word = off_mask;
        w.last_word     = last;
        return w;
    endfunction

    // A run of identical words at one point.
    task automatic send_uniform_run(input int unsigned x, input int unsigned y, input int len,
                                    input logic [WORD_W-1:0] img,
                                    input logic [WORD_W-1:0] on_mask,
                                    input logic [WORD_W-1:0] off_mask);
        int i;
        for (i = 0; i < len; i++)
            send_slice(make_slice(x, y, img, on_mask, off_mask, i == len - 1));
    endtask

    // Lower valid, wait for every score, then let the core settle.
    task automatic drain_scores();
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic core_regs_t make_regs(input int unsigned rows, input int unsigned cols,
                                             input int unsigned mh, input int unsigned on_bits,
                                             input int unsigned x0, input int unsigned y0,
                                             input int unsigned ww);
        core_regs_t c;
        c.image_rows    = rows[14:0];
        c.image_columns = cols[14:0];
        c.mask_height   = mh[7:0];
        c.on_count      = on_bits[12:0];
        c.window_x0     = x0[13:0];
        c.window_y0     = y0[13:0];
        c.window_width  = ww[14:0];
        return c;
    endfunction

    // One register write; valid stays up so back-to-back writes need no gap.
    // Bits above the register width carry junk when asked, to check masking.
    task automatic put_reg(input cfg_index_t idx, input int unsigned val, input int width);
        logic [CFG_W-1:0] keep;
        keep = CFG_W'((32'd1 << width) - 32'd1);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= (CFG_W'(val) & keep) | (pad_junk ? (CFG_W'($urandom) & ~keep) : '0);
        @(posedge clk);
    endtask

    task automatic apply_config(input core_regs_t c);
        put_reg(CFG_IMAGE_ROWS,    c.image_rows,    $bits(c.image_rows));
        put_reg(CFG_IMAGE_COLUMNS, c.image_columns, $bits(c.image_columns));
        put_reg(CFG_MASK_HEIGHT,   c.mask_height,   $bits(c.mask_height));
        put_reg(CFG_ON_COUNT,      c.on_count,      $bits(c.on_count));
        put_reg(CFG_WINDOW_X0,     c.window_x0,     $bits(c.window_x0));
        put_reg(CFG_WINDOW_Y0,     c.window_y0,     $bits(c.window_y0));
        put_reg(CFG_WINDOW_WIDTH,  c.window_width,  $bits(c.window_width));
        cfg_wr_en <= 1'b0;
        live_regs = c;
    endtask

    // Random 64-bit lane with a random density: full, empty, sparse, dense or plain.
    function automatic logic [WORD_W-1:0] random_lane();
        logic [WORD_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0: v = '1;
            1: v = v & {$urandom, $urandom};
            2: v = v | {$urandom, $urandom};
            3: v = v & {$urandom, $urandom} & {$urandom, $urandom};
            4: v = '0;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [COORD_W-1:0] clip_coord(input int v);
        return (v > 16383) ? 14'h3FFF : v[COORD_W-1:0];
    endfunction

    // One random run: mostly a point inside the cache window (fresh or a
    // repeat for a cache hit), some fully random points, and now and then
    // earlier words that stray to other coordinates.
    task automatic send_random_run();
        int                 roll;
        int                 len;
        int                 span_y;
        int                 k;
        int                 i;
        bit                 stray;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        slice_t             w;

        roll = $urandom_range(0, 99);
        if (roll < 25 && recent_points.size() != 0) begin
            k  = $urandom_range(0, recent_points.size() - 1);
            px = recent_points[k][COORD_W-1:0];
            py = recent_points[k][2*COORD_W-1:COORD_W];
        end else if (roll < 88) begin
            span_y = CACHE_DEPTH / live_regs.window_width;
            if (span_y > live_regs.image_rows)
                span_y = live_regs.image_rows;
            if (span_y < 1)
                span_y = 1;
            px = clip_coord(live_regs.window_x0 + $urandom_range(0, live_regs.window_width - 1));
            py = clip_coord(live_regs.window_y0 + $urandom_range(0, span_y - 1));
            recent_points.push_back({py, px});
            if (recent_points.size() > 16)
                void'(recent_points.pop_front());
        end else begin
            px = COORD_W'($urandom);
            py = COORD_W'($urandom);
        end

        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        stray = ($urandom_range(0, 9) == 0);
        for (i = 0; i < len; i++) begin
            w.x_pos         = px;
            w.y_pos         = py;
            if (stray && i != len - 1) begin
                w.x_pos = COORD_W'($urandom);
                w.y_pos = COORD_W'($urandom);
            end
            w.image_word    = random_lane();
            w.on_mask_word  = random_lane();
            // Thin the off mask half the time so positive scores are common.
            w.off_mask_word = random_lane()
                            & (($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : '1);
            w.last_word     = (i == len - 1);
            send_slice(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: one-by-one image, so only (0,0) is in range.
    task automatic test_reset_defaults();
        send_uniform_run(0, 0, 1, '1, '1, '0);    // 6400 saturates to 254, cached at slot 0
        send_uniform_run(1, 0, 1, '1, '1, '0);    // beyond the image: scores 0
        send_uniform_run(0, 0, 1, '0, '0, '0);    // cache hit, 254
        send_uniform_run(3, 5, 1, '1, '1, '0);    // beyond the image again
        drain_scores();
    endtask

    // Cache index limits, range limit, hits, clipping to 254, zero image.
    task automatic test_index_and_range_cases();
        apply_config(make_regs(64, 200, 16, 100, 8, 4, 64));
        send_uniform_run(7, 260, 1, '1, '1, '0);              // last slot in the cache: 64
        send_uniform_run(8, 260, 1, '1, '1, '0);              // one slot past the cache
        send_uniform_run(0, 4, 1, '1, '1, '0);                // left of the window
        send_uniform_run(16383, 16383, 1, {$urandom, $urandom}, '1, '0);
        send_uniform_run(199, 57, 1, '1, '1, '0);             // one past the range limit
        send_uniform_run(199, 56, 1, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom});               // exactly on the limit
        // Earlier words at other points; off sum beats on sum, so 0 is cached.
        send_slice(make_slice(0, 0, '1, 64'hFF, '1, 1'b0));
        send_slice(make_slice(16383, 16383, '1, '0, '1, 1'b0));
        send_slice(make_slice(10, 10, '1, '1, '1, 1'b1));
        send_uniform_run(10, 10, 1, '1, '1, '0);              // hit on a cached zero
        send_uniform_run(20, 20, 5, '1, '1, '0);              // 320 clips to 254
        send_uniform_run(20, 20, 1, '0, '0, '0);              // hit, 254
        send_uniform_run(30, 5, 1, '0, '1, '1);               // empty image
        send_uniform_run(7, 260, 1, '0, '0, '0);              // hit, 64
        drain_scores();
    endtask

    task automatic test_zero_divisor();
        apply_config(make_regs(64, 200, 16, 0, 8, 4, 64));
        send_uniform_run(40, 8, 1, 64'h3, 64'h3, '0);         // 2 * 100 / 1
        send_uniform_run(41, 8, 1, '1, 64'hF, '0);            // 400 clips to 254
        drain_scores();
    endtask

    // Every register at a high value, then at a low one with junk above
    // each register's width.
    task automatic test_register_extremes();
        pad_junk = 1'b0;
        apply_config(make_regs(16384, 16384, 128, 4096, 16383, 16383, 16384));
        send_uniform_run(16383, 16383, 1, '1, '1, '0);        // slot 0: hit
        send_uniform_run(16382, 16383, 2, '1, '1, '0);        // slot -1
        drain_scores();
        pad_junk = 1'b1;
        apply_config(make_regs(1, 1, 2, 1, 0, 0, 1));
        send_uniform_run(0, 0, 1, '0, '0, '0);                // hit
        send_uniform_run(0, 1, 1, '1, '1, '0);                // beyond the image
        drain_scores();
        pad_junk = 1'b0;
    endtask

    // Runs long enough to saturate the on sum; the first also saturates the off sum.
    task automatic test_sum_saturation();
        int i;
        apply_config(make_regs(64, 200, 16, 4096, 8, 4, 64));
        send_uniform_run(50, 30, 130, '1, '1, '1);            // both clip: 0
        for (i = 0; i < 130; i++)
            send_slice(make_slice(51, 30, '1, '1, (i < 90) ? '1 : '0, i == 129));
        drain_scores();
    endtask

    task automatic run_random_phase(input int budget, input bit wide);
        core_regs_t c;
        int         first;
        if (wide) begin
            c.image_rows    = 15'($urandom_range(1, 16384));
            c.image_columns = 15'($urandom_range(1, 16384));
            c.window_x0     = 14'($urandom_range(0, 16383));
            c.window_y0     = 14'($urandom_range(0, 16383));
            c.window_width  = 15'($urandom_range(1, 16384));
        end else begin
            c.image_rows    = 15'($urandom_range(1, 300));
            c.image_columns = 15'($urandom_range(1, 300));
            c.window_x0     = 14'($urandom_range(0, c.image_columns - 1));
            c.window_y0     = 14'($urandom_range(0, c.image_rows - 1));
            c.window_width  = 15'($urandom_range(1, 300));
        end
        c.mask_height = 8'($urandom_range(2, 128));
        case ($urandom_range(0, 19))
            0:       c.on_count = '0;
            1, 2, 3: c.on_count = 13'($urandom_range(1, 4096));
            default: c.on_count = 13'($urandom_range(1, 400));
        endcase
        pad_junk = ($urandom_range(0, 1) == 1);
        apply_config(c);
        recent_points.delete();
        first = slices_sent;
        while (slices_sent - first < budget)
            send_random_run();
        drain_scores();
    endtask

    // Hold m_tready off for a long stretch while words keep coming, so the
    // core holds its output and stalls its input.
    task automatic test_long_hold_off();
        int n;
        sender_idles     = 1'b0;
        hold_off_request = 1'b1;
        for (n = 0; n < 16; n++)
            send_random_run();
        sender_idles = 1'b1;
        drain_scores();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        live_regs = make_regs(1, 1, 2, 1, 0, 0, 1);
        on_total  = 0;
        off_total = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // The core sweeps its cache after reset; the first words just wait.
        test_reset_defaults();
        test_index_and_range_cases();
        test_zero_divisor();
        test_register_extremes();
        test_sum_saturation();

        run_random_phase(110, 1'b0);
        run_random_phase(110, 1'b1);
        sender_idles = 1'b0;
        run_random_phase(110, 1'b0);
        sender_idles = 1'b1;
        sink_idles   = 1'b0;
        run_random_phase(110, 1'b0);
        sink_idles   = 1'b1;
        run_random_phase(110, 1'b0);

        test_long_hold_off();

        // Last stretch at full rate on both sides.
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
        run_random_phase(120, 1'b0);

        if (mismatch_count == 0)
            $display("masked_popcount_correlation_core regression: pass");
        else
            $display("masked_popcount_correlation_core regression: fail");
        $finish;
    end

endmodule
